/* src/slrr_pkg.sv */
`default_nettype none

package slrr_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 32;

  // fixed field widths of the channels
  localparam int CMD_W     = 2;
  localparam int ID_W      = 4;
  localparam int KEY_IN_W  = 32;
  localparam int COUNT_W   = 5;

  localparam int NODE_W = $clog2(ENTRIES + 1);
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [NODE_W-1:0] SENTINEL = NODE_W'(ENTRIES);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_STEP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LINK1,
    S_LINK2,
    S_RMV,
    S_IDX,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

/* src/slrr_if.sv */
`default_nettype none

interface slrr_in_if import slrr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [ID_W-1:0]     item_id;
  logic [KEY_IN_W-1:0] item_key;

  modport source (output valid, cmd, item_id, item_key, input ready);
  modport sink   (input valid, cmd, item_id, item_key, output ready);
endinterface

interface slrr_out_if import slrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic               item_valid;
  logic [ID_W-1:0]    item_out;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, ok, item_valid, item_out, entry_count, input ready);
  modport sink   (input valid, ok, item_valid, item_out, entry_count, output ready);
endinterface

`default_nettype wire

/* src/sorted_list_with_round_robin_index.sv */
// Sorted list of item ids with a round-robin index.
// in_i carries one command per beat: insert (id, key), remove (id), get index
// item, step index. out_o returns exactly one result beat per command: ok,
// item_valid, item_out and the member count after the command.
// Links and keys sit in three registered-read memories; the sentinel's links
// are registers. One command is worked at a time; in_i is ready only while
// the sequencer idles.
// Steps from the accepted command to the result beat:
//   insert: a walk from the head past every member whose key is <= the new
//           key (one link read per cycle), then S_LINK1, S_LINK2, S_RESP
//   remove, get, step: S_RMV or S_IDX, then S_RESP; failed insert/remove,
//           get on an empty list and step from the sentinel: S_RESP only
// in_i is ready again in the cycle after the result is loaded.
// The result sits in an output register; if out_o stalls with a beat
// pending, the next result waits in the response step until that beat goes.
// Reset empties the list and parks the index on the sentinel; no clearing
// pass, the memories are always written before they are read.
`default_nettype none

module sorted_list_with_round_robin_index import slrr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  slrr_in_if.sink    in_i,
  slrr_out_if.source out_o
);

  state_e state_q, state_d;

  cmd_e                cmd_q, cmd_d;
  logic [IDX_W-1:0]    id_q, id_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [NODE_W-1:0]   at_q, at_d;
  logic [NODE_W-1:0]   head_q, head_d;
  logic [NODE_W-1:0]   tail_q, tail_d;
  logic [NODE_W-1:0]   cursor_q, cursor_d;
  logic [NODE_W-1:0]   count_q, count_d;
  logic [ENTRIES-1:0]  member_q, member_d;

  logic            res_ok_q, res_ok_d;
  logic            res_valid_q, res_valid_d;
  logic [ID_W-1:0] res_item_q, res_item_d;

  logic               out_valid_q;
  logic               out_ok_q;
  logic               out_item_valid_q;
  logic [ID_W-1:0]    out_item_q;
  logic [COUNT_W-1:0] out_count_q;

  // link and key memories
  logic [NODE_W-1:0]   next_mem [ENTRIES];
  logic [NODE_W-1:0]   prev_mem [ENTRIES];
  logic [KEY_BITS-1:0] key_mem  [ENTRIES];

  logic                nx_we, pv_we, ky_we;
  logic [IDX_W-1:0]    nx_waddr, pv_waddr, ky_waddr;
  logic [NODE_W-1:0]   nx_wdata, pv_wdata;
  logic [KEY_BITS-1:0] ky_wdata;
  logic [IDX_W-1:0]    nx_raddr, pv_raddr;
  logic [NODE_W-1:0]   nx_rdata_q, pv_rdata_q;
  logic [KEY_BITS-1:0] ky_rdata_q;

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_waddr] <= nx_wdata;
    nx_rdata_q <= next_mem[nx_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) prev_mem[pv_waddr] <= pv_wdata;
    pv_rdata_q <= prev_mem[pv_raddr];
  end

  // keys are read alongside the next link of the same node
  always_ff @(posedge clk_i) begin
    if (ky_we) key_mem[ky_waddr] <= ky_wdata;
    ky_rdata_q <= key_mem[nx_raddr];
  end

  // shared conditions
  logic              in_fire;
  cmd_e              in_cmd;
  logic              id_in_range;
  logic [IDX_W-1:0]  in_idx;
  logic              in_member;
  logic              walk_stop;
  logic              slot_free;
  logic [NODE_W-1:0] get_node;
  logic [NODE_W-1:0] before_node;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_cmd      = cmd_e'(in_i.cmd);
  assign id_in_range = (32'(in_i.item_id) < 32'(ENTRIES));
  assign in_idx      = IDX_W'(in_i.item_id);
  assign in_member   = id_in_range && member_q[in_idx];
  assign walk_stop   = (at_q == SENTINEL) || (key_q < ky_rdata_q);
  assign slot_free   = !out_valid_q || out_o.ready;
  assign get_node    = (cursor_q == SENTINEL) ? head_q : cursor_q;
  assign before_node = (at_q == SENTINEL) ? tail_q : pv_rdata_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_INSERT: state_d = (id_in_range && !in_member) ? S_WALK : S_RESP;
            CMD_REMOVE: state_d = in_member ? S_RMV : S_RESP;
            CMD_GET:    state_d = (count_q != '0) ? S_IDX : S_RESP;
            CMD_STEP:   state_d = (cursor_q != SENTINEL) ? S_IDX : S_RESP;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_WALK:  if (walk_stop) state_d = S_LINK1;
      S_LINK1: state_d = S_LINK2;
      S_LINK2: state_d = S_RESP;
      S_RMV:   state_d = S_RESP;
      S_IDX:   state_d = S_RESP;
      S_RESP:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d       = cmd_q;
    id_d        = id_q;
    key_d       = key_q;
    at_d        = at_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    member_d    = member_q;
    res_ok_d    = res_ok_q;
    res_valid_d = res_valid_q;
    res_item_d  = res_item_q;
    nx_we       = 1'b0;
    pv_we       = 1'b0;
    ky_we       = 1'b0;
    nx_waddr    = id_q;
    pv_waddr    = id_q;
    ky_waddr    = in_idx;
    nx_wdata    = at_q;
    pv_wdata    = before_node;
    ky_wdata    = KEY_BITS'(in_i.item_key);
    nx_raddr    = IDX_W'(at_q);
    pv_raddr    = IDX_W'(at_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d       = in_cmd;
          id_d        = in_idx;
          key_d       = KEY_BITS'(in_i.item_key);
          res_ok_d    = 1'b1;
          res_valid_d = 1'b0;
          res_item_d  = '0;
          unique case (in_cmd)
            CMD_INSERT: begin
              if (id_in_range && !in_member) begin
                member_d[in_idx] = 1'b1;
                count_d          = count_q + 1'b1;
                ky_we            = 1'b1;
                at_d             = head_q;
                nx_raddr         = IDX_W'(head_q);
              end else begin
                res_ok_d = 1'b0;
              end
            end
            CMD_REMOVE: begin
              if (in_member) begin
                nx_raddr = in_idx;
                pv_raddr = in_idx;
              end else begin
                res_ok_d = 1'b0;
              end
            end
            CMD_GET: begin
              if (count_q != '0) begin
                res_valid_d = 1'b1;
                res_item_d  = ID_W'(get_node);
                nx_raddr    = IDX_W'(get_node);
              end
            end
            CMD_STEP: begin
              // from the sentinel the successor is the head
              if (cursor_q == SENTINEL) cursor_d = head_q;
              else nx_raddr = IDX_W'(cursor_q);
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          pv_raddr = IDX_W'(at_q);
        end else begin
          at_d     = nx_rdata_q;
          nx_raddr = IDX_W'(nx_rdata_q);
        end
      end
      S_LINK1: begin
        // next[before] = id (head if before is the sentinel), prev[id] = before
        if (before_node == SENTINEL) begin
          head_d = NODE_W'(id_q);
        end else begin
          nx_we    = 1'b1;
          nx_waddr = IDX_W'(before_node);
          nx_wdata = NODE_W'(id_q);
        end
        pv_we    = 1'b1;
        pv_waddr = id_q;
        pv_wdata = before_node;
      end
      S_LINK2: begin
        // next[id] = at, prev[at] = id (tail if at is the sentinel)
        nx_we    = 1'b1;
        nx_waddr = id_q;
        nx_wdata = at_q;
        if (at_q == SENTINEL) begin
          tail_d = NODE_W'(id_q);
        end else begin
          pv_we    = 1'b1;
          pv_waddr = IDX_W'(at_q);
          pv_wdata = NODE_W'(id_q);
        end
      end
      S_RMV: begin
        if (pv_rdata_q == SENTINEL) begin
          head_d = nx_rdata_q;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = IDX_W'(pv_rdata_q);
          nx_wdata = nx_rdata_q;
        end
        if (nx_rdata_q == SENTINEL) begin
          tail_d = pv_rdata_q;
        end else begin
          pv_we    = 1'b1;
          pv_waddr = IDX_W'(nx_rdata_q);
          pv_wdata = pv_rdata_q;
        end
        member_d[id_q] = 1'b0;
        count_d        = count_q - 1'b1;
        if (cursor_q == NODE_W'(id_q)) cursor_d = nx_rdata_q;
      end
      S_IDX: begin
        if (cmd_q == CMD_GET) begin
          cursor_d = nx_rdata_q;
        end else begin
          cursor_d = (nx_rdata_q == SENTINEL) ? head_q : nx_rdata_q;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= SENTINEL;
      tail_q   <= SENTINEL;
      cursor_q <= SENTINEL;
      count_q  <= '0;
      member_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      member_q <= member_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    id_q        <= id_d;
    key_q       <= key_d;
    at_q        <= at_d;
    res_ok_q    <= res_ok_d;
    res_valid_q <= res_valid_d;
    res_item_q  <= res_item_d;
  end

  // output register
  logic out_load;
  assign out_load = (state_q == S_RESP) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ok_q         <= res_ok_q;
      out_item_valid_q <= res_valid_q;
      out_item_q       <= res_item_q;
      out_count_q      <= COUNT_W'(count_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = out_ok_q;
  assign out_o.item_valid  = out_item_valid_q;
  assign out_o.item_out    = out_item_q;
  assign out_o.entry_count = out_count_q;

  // checks
  a_count_matches_members: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(member_q) == 32'(count_q))
    else $error("member count disagrees with membership bits");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(ENTRIES))
    else $error("member count beyond capacity");

  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((head_q == SENTINEL) == (count_q == '0)))
    else $error("head link disagrees with member count");

  a_item_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_valid_q) |-> out_ok_q)
    else $error("returned item without success");

endmodule

`default_nettype wire
